// ===== hdl/fwrm_pkg.sv =====
package fwrm_pkg;

    // Width of one stored value and of the reported entry count.
    localparam int VALUE_W     = 31;
    localparam int COUNT_OUT_W = 6;

    // Codes carried by the command field of an input request.
    localparam logic CMD_PUSH = 1'b0;
    localparam logic CMD_POP  = 1'b1;

    // Decoded operation as it travels from the front to the back.
    typedef enum logic {
        OP_PUSH,
        OP_POP
    } t_op;

    // One classified request held in the queue between front and back.
    typedef struct packed {
        t_op                op;
        logic [VALUE_W-1:0] value;
    } t_req;

    // Sequencer states of the back part.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_POP_READ,
        ST_SCAN
    } t_state;

endpackage

// ===== hdl/fwrm_front.sv =====
module fwrm_front
    import fwrm_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic               i_command,
    input  logic [VALUE_W-1:0] i_value,
    output logic               o_req_valid,
    output t_req               o_req,
    input  logic               i_req_take
);

    // Two-entry request queue; the back takes from the head when it is ready.
    t_req       r_q [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_fill;
    logic [1:0] n_fill;
    logic       w_push;
    logic       w_pop;
    t_req       w_req;

    always_comb begin
        w_req.value = i_value;
        unique case (i_command)
            CMD_PUSH: w_req.op = OP_PUSH;
            CMD_POP:  w_req.op = OP_POP;
            default:  w_req.op = OP_PUSH;
        endcase
    end

    assign o_stall     = (r_fill == 2'd2);
    assign o_req_valid = (r_fill != 2'd0);
    assign o_req       = r_q[r_rd_ptr];
    assign w_push      = i_valid && !o_stall;
    assign w_pop       = i_req_take && o_req_valid;

    always_comb begin
        n_fill = r_fill;
        if (w_push && !w_pop) begin
            n_fill = r_fill + 2'd1;
        end else if (w_pop && !w_push) begin
            n_fill = r_fill - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_fill   <= 2'd0;
        end else begin
            r_fill <= n_fill;
            if (w_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (w_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr_ptr] <= w_req;
        end
    end

endmodule

// ===== hdl/fwrm_core.sv =====
module fwrm_core
    import fwrm_pkg::*;
#(
    parameter int DEPTH = 32
)
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_req_valid,
    input  t_req                   i_req,
    output logic                   o_req_take,
    output logic                   o_valid,
    input  logic                   i_stall,
    output logic [VALUE_W-1:0]     o_max_value,
    output logic [COUNT_OUT_W-1:0] o_item_count,
    output logic                   o_rejected
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [VALUE_W-1:0] r_mem [DEPTH];
    logic [VALUE_W-1:0] r_rd_data;

    t_state             r_state, n_state;
    logic [AW-1:0]      r_head, n_head;
    logic [AW-1:0]      r_tail, n_tail;
    logic [CW-1:0]      r_count, n_count;
    logic [VALUE_W-1:0] r_max, n_max;
    logic [VALUE_W-1:0] r_best, n_best;
    logic [AW-1:0]      r_scan_addr, n_scan_addr;
    logic [CW-1:0]      r_scan_left, n_scan_left;

    logic                   r_out_valid;
    logic [VALUE_W-1:0]     r_out_max;
    logic [COUNT_OUT_W-1:0] r_out_count;
    logic                   r_out_rej;

    logic               w_mem_we;
    logic [AW-1:0]      w_rd_addr;
    logic               w_res_load;
    logic               w_res_rej;
    logic [VALUE_W-1:0] w_best_now;
    logic               w_start;

    function automatic logic [AW-1:0] next_ptr(input logic [AW-1:0] p);
        logic [AW-1:0] r;
        r = (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
        return r;
    endfunction

    assign w_start    = i_req_valid && !r_out_valid;
    assign w_best_now = (r_rd_data > r_best) ? r_rd_data : r_best;

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_start && i_req.op == OP_POP && r_count != '0) begin
                    n_state = ST_POP_READ;
                end
            end
            ST_POP_READ: begin
                if (r_rd_data >= r_max && r_count != CW'(1)) begin
                    n_state = ST_SCAN;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_SCAN: begin
                if (r_scan_left == CW'(1)) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Datapath control and next register values.
    always_comb begin
        n_head      = r_head;
        n_tail      = r_tail;
        n_count     = r_count;
        n_max       = r_max;
        n_best      = r_best;
        n_scan_addr = r_scan_addr;
        n_scan_left = r_scan_left;
        w_mem_we    = 1'b0;
        w_rd_addr   = r_head;
        w_res_load  = 1'b0;
        w_res_rej   = 1'b0;
        o_req_take  = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (w_start) begin
                    o_req_take = 1'b1;
                    if (i_req.op == OP_PUSH) begin
                        w_res_load = 1'b1;
                        if (r_count == CW'(DEPTH)) begin
                            w_res_rej = 1'b1;
                        end else begin
                            w_mem_we = 1'b1;
                            n_tail   = next_ptr(r_tail);
                            n_count  = r_count + CW'(1);
                            if (i_req.value > r_max) begin
                                n_max = i_req.value;
                            end
                        end
                    end else if (r_count == '0) begin
                        w_res_load = 1'b1;
                        w_res_rej  = 1'b1;
                    end
                end
            end
            ST_POP_READ: begin
                n_head  = next_ptr(r_head);
                n_count = r_count - CW'(1);
                if (r_rd_data >= r_max) begin
                    if (r_count == CW'(1)) begin
                        n_max      = '0;
                        w_res_load = 1'b1;
                    end else begin
                        n_best      = '0;
                        n_scan_addr = next_ptr(r_head);
                        n_scan_left = r_count - CW'(1);
                        w_rd_addr   = n_scan_addr;
                    end
                end else begin
                    w_res_load = 1'b1;
                end
            end
            ST_SCAN: begin
                if (r_scan_left == CW'(1)) begin
                    n_max      = w_best_now;
                    w_res_load = 1'b1;
                end else begin
                    n_best      = w_best_now;
                    n_scan_left = r_scan_left - CW'(1);
                    n_scan_addr = next_ptr(r_scan_addr);
                    w_rd_addr   = n_scan_addr;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[r_tail] <= i_req.value;
        end
        r_rd_data <= r_mem[w_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_head      <= '0;
            r_tail      <= '0;
            r_count     <= '0;
            r_max       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
            r_max   <= n_max;
            if (w_res_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_best      <= n_best;
        r_scan_addr <= n_scan_addr;
        r_scan_left <= n_scan_left;
        if (w_res_load) begin
            r_out_max   <= n_max;
            r_out_count <= COUNT_OUT_W'(n_count);
            r_out_rej   <= w_res_rej;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_max_value  = r_out_max;
    assign o_item_count = r_out_count;
    assign o_rejected   = r_out_rej;

endmodule

// ===== hdl/fifo_with_running_max.sv =====
// Bounded FIFO of DEPTH 31-bit values that reports, for every request, the
// largest value it holds afterwards (0 when empty), the entry count and a
// rejected flag for a push into a full queue or a pop from an empty one.
// A two-entry request queue at the front accepts requests while the back is
// busy or its result waits to be taken. Once the back starts a request, a
// push or a rejected request is done in the idle state, a pop that keeps the
// maximum or empties the queue finishes in the pop read state, and a pop that
// removes the maximum while entries remain goes on into the rescan, which
// reads the remaining entries one per cycle through the single read port
// of the entry memory. The result then sits in an output register until it
// is taken, and the back starts no new request while that register is full.
module fifo_with_running_max
    import fwrm_pkg::*;
#(
    parameter int DEPTH = 32
)
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_stall,
    input  logic                   i_command,
    input  logic [VALUE_W-1:0]     i_value,
    output logic                   o_valid,
    input  logic                   i_stall,
    output logic [VALUE_W-1:0]     o_max_value,
    output logic [COUNT_OUT_W-1:0] o_item_count,
    output logic                   o_rejected
);

    // Classified requests flow from the front to the back through this link.
    logic w_req_valid;
    t_req w_req;
    logic w_req_take;

    // The front decodes each request and buffers it.
    fwrm_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_command   (i_command),
        .i_value     (i_value),
        .o_req_valid (w_req_valid),
        .o_req       (w_req),
        .i_req_take  (w_req_take)
    );

    // The back owns the entry memory, the pointers, the count and the
    // running maximum, and sequences the rescan after the maximum leaves.
    fwrm_core #(
        .DEPTH (DEPTH)
    ) u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_valid  (w_req_valid),
        .i_req        (w_req),
        .o_req_take   (w_req_take),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_max_value  (o_max_value),
        .o_item_count (o_item_count),
        .o_rejected   (o_rejected)
    );

endmodule
